// ----- rtl/largest_proper_prime_divisor_unit_defines.svh -----
`ifndef LARGEST_PROPER_PRIME_DIVISOR_UNIT_DEFINES_SVH
`define LARGEST_PROPER_PRIME_DIVISOR_UNIT_DEFINES_SVH

// Clocked on clk, off while rst_n is low.
`define LPPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked on clk, checked during reset too.
`define LPPD_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/lppd_pkg.sv -----
`default_nettype none

package lppd_pkg;

    localparam int VALUE_WIDTH   = 31;
    localparam int DIVISOR_WIDTH = VALUE_WIDTH - 1;
    localparam int CNT_WIDTH     = $clog2(VALUE_WIDTH + 1);

    typedef struct packed {
        logic load;
        logic div_start;
        logic take_factor;
        logic next_d;
        logic finish;
    } lppd_cmd_t;

    typedef struct packed {
        logic div_done;
        logic quo_lt_d;
        logic rem_zero;
    } lppd_sts_t;

endpackage

`default_nettype wire

// ----- rtl/largest_proper_prime_divisor_unit.sv -----
// Trial divisions per item: up to about sqrt(value)/2, plus one per prime factor.
// Each trial division runs one bit per cycle through a single restoring divider.
// Throughput: one item at a time; the next item is taken while a result waits.
// Reset (rst_n low, asynchronous): controller idles, no result is pending.
`default_nettype none

module largest_proper_prime_divisor_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic [lppd_pkg::VALUE_WIDTH-1:0]  value,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [lppd_pkg::DIVISOR_WIDTH-1:0]     divisor,
    output logic                                   found
);
    import lppd_pkg::*;

    lppd_cmd_t cmd;
    lppd_sts_t sts;

    lppd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    lppd_dp u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .sts     (sts),
        .value   (value),
        .divisor (divisor),
        .found   (found)
    );

endmodule

`default_nettype wire

// ----- rtl/lppd_dp.sv -----
`default_nettype none

module lppd_dp (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire lppd_pkg::lppd_cmd_t               cmd,
    output lppd_pkg::lppd_sts_t                    sts,
    input  wire logic [lppd_pkg::VALUE_WIDTH-1:0]  value,
    output logic [lppd_pkg::DIVISOR_WIDTH-1:0]     divisor,
    output logic                                   found
);
    import lppd_pkg::*;

    logic [VALUE_WIDTH-1:0]   rest_reg;
    logic [VALUE_WIDTH-1:0]   d_reg;
    logic [VALUE_WIDTH-1:0]   best_reg;
    logic [VALUE_WIDTH-1:0]   quo_reg;
    logic [VALUE_WIDTH-1:0]   rem_reg;
    logic [CNT_WIDTH-1:0]     cnt_reg;
    logic                     busy_reg;
    logic [DIVISOR_WIDTH-1:0] divisor_reg;
    logic                     found_reg;

    logic [VALUE_WIDTH:0]     shifted;
    logic [VALUE_WIDTH:0]     diff;
    logic                     fits;
    logic                     stepping;
    logic [VALUE_WIDTH-1:0]   result;

    assign shifted  = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign diff     = shifted - {1'b0, d_reg};
    assign fits     = shifted >= {1'b0, d_reg};
    assign stepping = busy_reg && (cnt_reg != '0);

    assign sts.div_done = busy_reg && (cnt_reg == '0);
    assign sts.quo_lt_d = quo_reg < d_reg;
    assign sts.rem_zero = rem_reg == '0;

    always_comb
    begin
        if (best_reg == '0)
        begin
            result = '0;
        end
        else if ((rest_reg > VALUE_WIDTH'(1)) && (rest_reg > best_reg))
        begin
            result = rest_reg;
        end
        else
        begin
            result = best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_WIDTH'(VALUE_WIDTH);
        end
        else if (stepping)
        begin
            cnt_reg <= cnt_reg - CNT_WIDTH'(1);
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rest_reg <= value;
            d_reg    <= VALUE_WIDTH'(2);
            best_reg <= '0;
        end
        else if (cmd.take_factor)
        begin
            best_reg <= d_reg;
            rest_reg <= quo_reg;
        end
        else if (cmd.next_d)
        begin
            d_reg <= (d_reg == VALUE_WIDTH'(2)) ? VALUE_WIDTH'(3) : d_reg + VALUE_WIDTH'(2);
        end

        if (cmd.div_start)
        begin
            quo_reg <= rest_reg;
            rem_reg <= '0;
        end
        else if (stepping)
        begin
            rem_reg <= fits ? diff[VALUE_WIDTH-1:0] : shifted[VALUE_WIDTH-1:0];
            quo_reg <= {quo_reg[VALUE_WIDTH-2:0], fits};
        end

        if (cmd.finish)
        begin
            divisor_reg <= result[DIVISOR_WIDTH-1:0];
            found_reg   <= best_reg != '0;
        end
    end

    assign divisor = divisor_reg;
    assign found   = found_reg;

endmodule

`default_nettype wire

// ----- rtl/lppd_ctrl.sv -----
`default_nettype none

module lppd_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output lppd_pkg::lppd_cmd_t        cmd,
    input  wire lppd_pkg::lppd_sts_t   sts
);
    import lppd_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_START  = 2'd1;
    localparam logic [1:0] S_WAIT   = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_START;
                end
            end
            S_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_WAIT;
            end
            S_WAIT:
            begin
                if (sts.div_done)
                begin
                    if (sts.quo_lt_d)
                    begin
                        state_next = S_FINISH;
                    end
                    else if (sts.rem_zero)
                    begin
                        cmd.take_factor = 1'b1;
                        state_next      = S_START;
                    end
                    else
                    begin
                        cmd.next_d = 1'b1;
                        state_next = S_START;
                    end
                end
            end
            S_FINISH:
            begin
                // hold until the output slot is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

// ----- rtl/lppd_checker.sv -----
`default_nettype none

`include "largest_proper_prime_divisor_unit_defines.svh"

module lppd_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    input  wire logic                              in_ready,
    input  wire logic                              out_valid,
    input  wire logic                              out_ready,
    input  wire logic [lppd_pkg::DIVISOR_WIDTH-1:0] divisor,
    input  wire logic                              found
);
    import lppd_pkg::*;

    `LPPD_ASSERT_RST(a_no_result_in_reset, !rst_n |-> !out_valid, "result valid during reset")

    `LPPD_ASSERT(a_one_item_at_a_time, in_valid && in_ready |=> !in_ready, "second item taken while busy")

    `LPPD_ASSERT(a_none_means_zero, out_valid && !found |-> divisor == '0, "nonzero divisor without found")

    `LPPD_ASSERT(a_found_is_prime_sized, out_valid && found |-> divisor >= DIVISOR_WIDTH'(2), "found divisor below two")

    `LPPD_ASSERT(a_result_holds, out_valid && !out_ready |=> out_valid && $stable(divisor) && $stable(found), "stalled result changed")

endmodule

bind largest_proper_prime_divisor_unit lppd_checker u_lppd_checker (.*);

`default_nettype wire

// ----- tb/largest_proper_prime_divisor_unit_test.sv -----
`timescale 1ns / 1ps

module largest_proper_prime_divisor_unit_test;

    import lppd_pkg::*;

    localparam int RX_HOLD_CYCLES = 5000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct packed {
        logic [VALUE_WIDTH-1:0]   value;
        logic [DIVISOR_WIDTH-1:0] divisor;
        logic                     found;
    } factor_result_t;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     in_valid  = 1'b0;
    logic                     in_ready;
    logic [VALUE_WIDTH-1:0]   value     = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic [DIVISOR_WIDTH-1:0] divisor;
    logic                     found;

    logic                     in_taken  = 1'b0;
    logic                     rx_hold   = 1'b0;
    logic                     hold_go   = 1'b0;
    int                       tx_idle_pct = 0;
    int                       rx_idle_pct = 0;

    logic [VALUE_WIDTH-1:0]   values_pending[$];
    factor_result_t           results_expected[$];

    int mismatches     = 0;
    int values_sent    = 0;
    int results_seen   = 0;
    int factors_found  = 0;

    largest_proper_prime_divisor_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .divisor   (divisor),
        .found     (found)
    );

    always #5 clk = ~clk;

    function automatic factor_result_t largest_proper_prime(input logic [VALUE_WIDTH-1:0] n);
        factor_result_t   r;
        longint unsigned  rest;
        longint unsigned  best;
        longint unsigned  d;
        r.value = n;
        rest = 64'(n);
        best = 0;
        if (rest >= 4)
        begin
            d = 2;
            while (d <= rest / d)
            begin
                while (rest % d == 0)
                begin
                    best = d;
                    rest = rest / d;
                end
                d = (d == 2) ? 3 : d + 2;
            end
            if (best != 0 && rest > 1 && rest > best)
                best = rest;
        end
        r.divisor = best[DIVISOR_WIDTH-1:0];
        r.found   = (best != 0);
        return r;
    endfunction

    function automatic logic [VALUE_WIDTH-1:0] random_value();
        longint unsigned v;
        case ($urandom_range(0, 2))
            0:       v = 64'($urandom_range(0, 4095));
            1:       v = 64'($urandom_range(1, 16383)) << $urandom_range(0, 17);
            default: v = 64'($urandom_range(1, 1023)) * 64'($urandom_range(1, 1023))
                         * 64'($urandom_range(1, 1023));
        endcase
        return v[VALUE_WIDTH-1:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [VALUE_WIDTH-1:0] n,
                                   input longint unsigned got, input longint unsigned want);
        $display("ERROR at %0t: value %0d, %s got %0d, expected %0d", $time, n, what, got, want);
        mismatches++;
    endtask

    task automatic drain();
        while (values_pending.size() != 0 || in_valid || results_expected.size() != 0)
            @(posedge clk);
    endtask

    // hold the current transfer until accepted, then offer the next value or idle
    always @(negedge clk)
    begin : drive_values
        logic offer;
        if (!(in_valid && !in_taken))
        begin
            offer = values_pending.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct;
            if (offer)
                value <= values_pending.pop_front();
            in_valid <= offer;
        end
    end

    always @(negedge clk)
        out_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);

    initial
    begin
        @(posedge hold_go);
        rx_hold = 1'b1;
        repeat (RX_HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
    end

    always @(posedge clk)
    begin : check_results
        factor_result_t want;
        in_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                results_seen++;
                if (results_expected.size() == 0)
                begin
                    report_mismatch("unexpected result, divisor", '0, 64'(divisor), 64'(0));
                end
                else
                begin
                    want = results_expected.pop_front();
                    if (divisor !== want.divisor)
                        report_mismatch("divisor", want.value, 64'(divisor),
                                        64'(want.divisor));
                    if (found !== want.found)
                        report_mismatch("found", want.value, 64'(found), 64'(want.found));
                    if (want.found)
                        factors_found++;
                end
            end
            if (in_valid && in_ready)
            begin
                results_expected.push_back(largest_proper_prime(value));
                values_sent++;
            end
        end
    end

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        tx_idle_pct = 18;
        rx_idle_pct = 83;
        values_pending = '{
            31'd0, 31'd1, 31'd2, 31'd3, 31'd4, 31'd5, 31'd6, 31'd8, 31'd9, 31'd12,
            31'd18, 31'd25, 31'd49, 31'd97, 31'd121, 31'd1024, 31'd30030, 31'd131042,
            31'h2AAAAAAA, 31'h55555555, 31'h40000000, 31'h3FFFFFFF, 31'h7FFFFFFE,
            31'h7FFFFFFF
        };
        repeat (26) values_pending.push_back(random_value());
        drain();

        tx_idle_pct = 83;
        rx_idle_pct = 18;
        repeat (24) values_pending.push_back(random_value());
        drain();

        // stall the output so the block fills up and backs up its input
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        repeat (4) values_pending.push_back(31'($urandom_range(0, 4095)));
        repeat (22) values_pending.push_back(random_value());
        hold_go = 1'b1;
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d values and checked %0d results, %0d with a proper prime divisor,",
                 values_sent, results_seen, factors_found);
        $display("under sender and receiver idling, a long output stall and no idling.");
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #200_000_000;
        $display("Timeout with %0d results still expected", results_expected.size());
        $display("Mismatches found");
        $finish;
    end

endmodule
